/* sv/serial_block_transfer_engine_defines.svh */
// Assertion macros for the serial block transfer engine.
// Included by sbte_fsm, the module that carries concurrent checks; it needs clock and reset in scope.
`ifndef SERIAL_BLOCK_TRANSFER_ENGINE_DEFINES_SVH
`define SERIAL_BLOCK_TRANSFER_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sbte_pkg.sv */
// Shared types and constants for the serial block transfer engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbte_pkg;

   localparam logic [7:0] SYNC_SENDER   = 8'hA5;
   localparam logic [7:0] SYNC_RECEIVER = 8'h5A;
   localparam logic [7:0] CODE_ACK      = 8'h06;
   localparam logic [7:0] CODE_NAK      = 8'h15;
   localparam logic [7:0] CODE_IDLE     = 8'h00;

   localparam logic [8:0] MAX_LENGTH = 9'd256;

   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_EXCHANGE = 1'b1;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   localparam logic [2:0] CSR_ROLE_RECEIVER = 3'd0;
   localparam logic [2:0] CSR_PATIENT_MODE  = 3'd1;
   localparam logic [2:0] CSR_RETRY_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_TRY_BUDGET    = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_BUDGET = 3'd4;
   localparam logic [2:0] CSR_BLOCK_LENGTH  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SYNC  = 3'd1,
      PH_DATA  = 3'd2,
      PH_CKLO  = 3'd3,
      PH_CKHI  = 3'd4,
      PH_FINAL = 3'd5,
      PH_NAK   = 3'd6
   } phase_type;

   typedef struct packed {
      logic        role_receiver;
      logic        patient_mode;
      logic [3:0]  retry_limit;
      logic [15:0] sync_try_budget;
      logic [15:0] sync_timeout_budget;
      logic [8:0]  block_length;
   } cfg_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] peer_byte;
      logic       timed_out;
      logic       cancel_held;
      logic [7:0] sent_data;
   } item_type;

   typedef struct packed {
      logic [7:0] next_tx_byte;
      logic       next_from_buffer;
      logic [7:0] next_index;
      logic       store_valid;
      logic [7:0] store_index;
      logic [1:0] status;
   } rsp_type;

endpackage

/* sv/serial_block_transfer_engine.sv */
// Serial block transfer engine: one side of a full-duplex byte-exchange block transfer.
// Each beat on req_ is either a start or the outcome of one byte exchange, and yields
// exactly one rsp_ beat saying what to drive next, where to store received data and
// whether the transfer is busy, done or failed. One beat is taken every clock cycle
// while rsp_tready stays high; a beat is held in the input register, and its result
// is captured in the result register, set by the single pass of sequencer logic
// between the two. A result that is not taken holds the sequencer: the input
// register still takes one more beat, then req_tready stays low until rsp_tready
// returns. Configuration is to be written through csr_ only while no beat is in flight;
// the block itself does not enforce this, and there is no start-up clearing pass.
// Depends on sbte_pkg, sbte_csr and sbte_fsm.
`timescale 1ns / 1ps

module serial_block_transfer_engine
   import sbte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // peer_byte, timed_out, cancel_held, sent_data, zero pad
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // next_tx_byte, next_from_buffer, next_index,
                                    // store_valid, store_index, status, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type  cfg;
   item_type item_ff, item_in;
   logic     in_valid_ff, in_valid_in;
   rsp_type  rsp_ff;
   rsp_type  result;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     fire;
   logic     req_take;

   sbte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbte_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in.req_type    = req_tuser;
      item_in.peer_byte   = req_tdata[7:0];
      item_in.timed_out   = req_tdata[8];
      item_in.cancel_held = req_tdata[9];
      item_in.sent_data   = req_tdata[17:10];
   end

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.status, rsp_ff.store_index, rsp_ff.store_valid,
                        rsp_ff.next_index, rsp_ff.next_from_buffer, rsp_ff.next_tx_byte};

endmodule

/* sv/sbte_csr.sv */
// Configuration register file of the serial block transfer engine.
// Depends on sbte_pkg for the register indexes and the cfg_type bundle.
`timescale 1ns / 1ps

module sbte_csr
   import sbte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROLE_RECEIVER:  cfg_in.role_receiver       = csr_data[0];
            CSR_PATIENT_MODE:   cfg_in.patient_mode        = csr_data[0];
            CSR_RETRY_LIMIT:    cfg_in.retry_limit         = csr_data[3:0];
            CSR_TRY_BUDGET:     cfg_in.sync_try_budget     = csr_data;
            CSR_TIMEOUT_BUDGET: cfg_in.sync_timeout_budget = csr_data;
            CSR_BLOCK_LENGTH:   cfg_in.block_length        = csr_data[8:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.role_receiver       <= 1'b0;
         cfg_ff.patient_mode        <= 1'b0;
         cfg_ff.retry_limit         <= 4'd8;
         cfg_ff.sync_try_budget     <= 16'd2048;
         cfg_ff.sync_timeout_budget <= 16'd400;
         cfg_ff.block_length        <= 9'd250;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/sbte_fsm.sv */
// Transfer sequencer: phase, round and sync counters, Fletcher-style sums kept modulo 256, result decode.
// Depends on sbte_pkg and on the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "serial_block_transfer_engine_defines.svh"

module sbte_fsm
   import sbte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     fire,
   input  item_type item,
   output rsp_type  result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  round_count_ff, round_count_in;
   logic [15:0] sync_tries_ff, sync_tries_in;
   logic [15:0] sync_timeouts_ff, sync_timeouts_in;
   logic        cancel_armed_ff, cancel_armed_in;
   logic [8:0]  byte_index_ff, byte_index_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [7:0]  got_check_low_ff, got_check_low_in;

   logic [7:0]  want_sync;
   logic [8:0]  eff_len;
   logic [7:0]  data_byte;
   logic        begin_req;
   logic [3:0]  begin_rc;
   logic [1:0]  status;
   logic        store_valid;
   logic [7:0]  store_index;

   assign want_sync = cfg.role_receiver ? SYNC_SENDER : SYNC_RECEIVER;
   assign eff_len   = (cfg.block_length > MAX_LENGTH) ? MAX_LENGTH : cfg.block_length;
   assign data_byte = cfg.role_receiver ? item.peer_byte : item.sent_data;

   always_comb begin : next_state
      phase_in         = phase_ff;
      round_count_in   = round_count_ff;
      sync_tries_in    = sync_tries_ff;
      sync_timeouts_in = sync_timeouts_ff;
      cancel_armed_in  = cancel_armed_ff;
      byte_index_in    = byte_index_ff;
      sum_low_in       = sum_low_ff;
      sum_high_in      = sum_high_ff;
      got_check_low_in = got_check_low_ff;
      begin_req        = 1'b0;
      begin_rc         = round_count_ff + 4'd1;
      status           = ST_BUSY;
      store_valid      = 1'b0;
      store_index      = 8'd0;

      if (fire) begin
         if (item.req_type == REQ_START) begin
            begin_req = 1'b1;
            begin_rc  = 4'd0;
         end else begin
            case (phase_ff)
               PH_SYNC: begin
                  if (!item.timed_out && item.peer_byte == want_sync) begin
                     byte_index_in = 9'd0;
                     sum_low_in    = 8'd0;
                     sum_high_in   = 8'd0;
                     phase_in      = (eff_len == 9'd0) ? PH_CKLO : PH_DATA;
                  end else if (item.cancel_held && cancel_armed_ff) begin
                     phase_in = PH_IDLE;
                     status   = ST_FAIL;
                  end else begin
                     if (!item.cancel_held) begin
                        cancel_armed_in = 1'b1;
                     end
                     sync_tries_in = sync_tries_ff + 16'd1;
                     if (item.timed_out && !cfg.patient_mode &&
                         sync_timeouts_ff + 16'd1 == cfg.sync_timeout_budget) begin
                        sync_timeouts_in = sync_timeouts_ff + 16'd1;
                        sync_tries_in    = sync_tries_ff;
                        phase_in         = PH_IDLE;
                        status           = ST_FAIL;
                     end else begin
                        if (item.timed_out && !cfg.patient_mode) begin
                           sync_timeouts_in = sync_timeouts_ff + 16'd1;
                        end
                        if (sync_tries_in == cfg.sync_try_budget) begin
                           if (cfg.patient_mode) begin
                              sync_tries_in = 16'd0;
                           end else begin
                              begin_req = 1'b1;
                           end
                        end
                     end
                  end
               end
               PH_DATA: begin
                  if (item.timed_out) begin
                     begin_req = 1'b1;
                  end else begin
                     store_valid   = cfg.role_receiver;
                     store_index   = cfg.role_receiver ? byte_index_ff[7:0] : 8'd0;
                     sum_low_in    = sum_low_ff + data_byte;
                     sum_high_in   = sum_high_ff + sum_low_in;
                     byte_index_in = byte_index_ff + 9'd1;
                     if (byte_index_in >= eff_len) begin
                        phase_in = PH_CKLO;
                     end
                  end
               end
               PH_CKLO: begin
                  if (item.timed_out) begin
                     begin_req = 1'b1;
                  end else begin
                     got_check_low_in = item.peer_byte;
                     phase_in         = PH_CKHI;
                  end
               end
               PH_CKHI: begin
                  if (cfg.role_receiver) begin
                     phase_in = (!item.timed_out && got_check_low_ff == sum_low_ff &&
                                 item.peer_byte == sum_high_ff) ? PH_FINAL : PH_NAK;
                  end else if (item.timed_out) begin
                     begin_req = 1'b1;
                  end else begin
                     phase_in = PH_FINAL;
                  end
               end
               PH_FINAL: begin
                  if (cfg.role_receiver || (!item.timed_out && item.peer_byte == CODE_ACK)) begin
                     phase_in = PH_IDLE;
                     status   = ST_DONE;
                  end else begin
                     begin_req = 1'b1;
                  end
               end
               PH_NAK: begin
                  begin_req = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end

         if (begin_req) begin
            round_count_in = begin_rc;
            if (begin_rc >= cfg.retry_limit ||
                (cfg.sync_try_budget == 16'd0 && !cfg.patient_mode)) begin
               phase_in = PH_IDLE;
               status   = ST_FAIL;
            end else begin
               phase_in         = PH_SYNC;
               sync_tries_in    = 16'd0;
               sync_timeouts_in = 16'd0;
               cancel_armed_in  = !item.cancel_held;
            end
         end
      end
   end

   always_comb begin : outputs
      result.next_tx_byte     = CODE_IDLE;
      result.next_from_buffer = 1'b0;
      result.next_index       = 8'd0;
      result.store_valid      = store_valid;
      result.store_index      = store_index;
      result.status           = status;
      case (phase_in)
         PH_SYNC:  result.next_tx_byte = cfg.role_receiver ? SYNC_RECEIVER : SYNC_SENDER;
         PH_DATA: begin
            if (!cfg.role_receiver) begin
               result.next_from_buffer = 1'b1;
               result.next_index       = byte_index_in[7:0];
            end
         end
         PH_CKLO:  result.next_tx_byte = cfg.role_receiver ? CODE_IDLE : sum_low_in;
         PH_CKHI:  result.next_tx_byte = cfg.role_receiver ? CODE_IDLE : sum_high_in;
         PH_FINAL: result.next_tx_byte = cfg.role_receiver ? CODE_ACK : CODE_IDLE;
         PH_NAK:   result.next_tx_byte = CODE_NAK;
         default:  result.next_tx_byte = CODE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         round_count_ff   <= 4'd0;
         sync_tries_ff    <= 16'd0;
         sync_timeouts_ff <= 16'd0;
         cancel_armed_ff  <= 1'b0;
         byte_index_ff    <= 9'd0;
         sum_low_ff       <= 8'd0;
         sum_high_ff      <= 8'd0;
         got_check_low_ff <= 8'd0;
      end else begin
         phase_ff         <= phase_in;
         round_count_ff   <= round_count_in;
         sync_tries_ff    <= sync_tries_in;
         sync_timeouts_ff <= sync_timeouts_in;
         cancel_armed_ff  <= cancel_armed_in;
         byte_index_ff    <= byte_index_in;
         sum_low_ff       <= sum_low_in;
         sum_high_ff      <= sum_high_in;
         got_check_low_ff <= got_check_low_in;
      end
   end

   `SBTE_ASSERT_NEXT(a_end_goes_idle, fire && result.status != ST_BUSY, phase_ff == PH_IDLE, "transfer ended but phase not idle")
   `SBTE_ASSERT_NOW(a_store_rx_data, fire && result.store_valid, cfg.role_receiver && phase_ff == PH_DATA, "store outside receiver data phase")
   `SBTE_ASSERT_NOW(a_buffer_tx_data, fire && result.next_from_buffer, !cfg.role_receiver && phase_in == PH_DATA && result.next_tx_byte == CODE_IDLE, "buffer send outside sender data phase")
   `SBTE_ASSERT_NEXT(a_start_resets_round, fire && item.req_type == REQ_START, round_count_ff == 4'd0 && (phase_ff == PH_IDLE || sync_tries_ff == 16'd0), "start did not reset the round")

endmodule
